@@ rtl/core/adaptive_smooth_clock_defines.svh @@
// assertion helpers shared by the rtl of the adaptive smooth clock
`ifndef ADAPTIVE_SMOOTH_CLOCK_DEFINES_SVH
`define ADAPTIVE_SMOOTH_CLOCK_DEFINES_SVH

`ifndef SYNTH
`define ASC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("asc assertion failed");
`define ASC_ASSERT_NEXT(name, clk, rst_n, cond, nxt) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("asc next-cycle assertion failed");
`else
`define ASC_ASSERT(name, clk, rst_n, prop)
`define ASC_ASSERT_NEXT(name, clk, rst_n, cond, nxt)
`endif

`endif

@@ rtl/core/asc_pkg.sv @@
package asc_pkg;

    localparam int TIME_WIDTH_DEF = 48;

    localparam int OP_W    = 2;
    localparam int NOW_W   = 47;
    localparam int TGT_W   = 48;
    localparam int TL_W    = 32;
    localparam int SPD_W   = 28;
    localparam int SPIKE_W = 6;
    localparam int OUT_W   = 48;
    localparam int PROD_W  = 64;
    localparam int REM_W   = 30;
    localparam int Q_W     = 17;

    localparam int US_SHIFT = 6;
    localparam int QUO_LSB  = 44;

    localparam logic [SPD_W-1:0]   SPEED_RESET = 28'd19661;
    localparam logic [SPD_W-1:0]   SPEED_FLOOR = 28'd131072;
    localparam logic [SPD_W-1:0]   SPEED_CEIL  = 28'd1966080;
    localparam logic [PROD_W-1:0]  DT_SAT      = 64'd65536000000;
    localparam logic [TL_W-1:0]    SPIKE_LIMIT = 32'd50000;
    localparam logic [SPIKE_W-1:0] SPIKE_MAX   = 6'd50;
    localparam logic [SPIKE_W-1:0] SPIKE_STEP  = 6'd5;
    localparam logic [SPIKE_W-1:0] SPIKE_GATE  = 6'd15;
    localparam logic [31:0]        RECIP5      = 32'hCCCCCCCD;
    localparam logic [31:0]        RECIP_US    = 32'd1125899907;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY,
        OP_RESET,
        OP_UPDATE,
        OP_SET_SPEED
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP,
        S_DECAY,
        S_DECAY_WB,
        S_SETUP,
        S_PROD_LO,
        S_PROD_HI,
        S_PROD_SUM,
        S_DIV,
        S_MQ_LO,
        S_MQ_HI,
        S_MQ_SUM,
        S_FINAL,
        S_OUT
    } t_state;

endpackage

@@ rtl/core/asc_in_if.sv @@
interface asc_in_if;
    logic                              valid;
    logic                              ready;
    logic [asc_pkg::OP_W-1:0]          operation;
    logic [asc_pkg::NOW_W-1:0]         now_us;
    logic signed [asc_pkg::TGT_W-1:0]  target_us;
    logic signed [asc_pkg::TL_W-1:0]   time_left_us;
    logic                              direction;
    logic [asc_pkg::SPD_W-1:0]         speed_value;

    modport source (
        output valid, operation, now_us, target_us, time_left_us, direction,
               speed_value,
        input  ready
    );
    modport sink (
        input  valid, operation, now_us, target_us, time_left_us, direction,
               speed_value,
        output ready
    );
endinterface

@@ rtl/core/asc_out_if.sv @@
interface asc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [asc_pkg::OUT_W-1:0]  smoothed_time_us;
    logic                              update_applied;
    logic [asc_pkg::SPIKE_W-1:0]       spike_level;

    modport source (
        output valid, smoothed_time_us, update_applied, spike_level,
        input  ready
    );
    modport sink (
        input  valid, smoothed_time_us, update_applied, spike_level,
        output ready
    );
endinterface

@@ rtl/core/adaptive_smooth_clock.sv @@
// adaptive smooth clock
// i_in carries one command beat: operation, local time now_us, target_us,
// time_left_us, direction and speed_value. o_out returns one beat per
// command: the smoothed time at now_us after the command, whether the
// target was taken and the spike counter.
// one command is worked at a time; i_in.ready is high only while the
// sequencer idles, so the next command can be taken in the cycle after a
// result is loaded. a reset-to-target command goes straight to the output
// stage. other commands skip the multiplies when the blend factor is 0 or
// saturated up front, and stop after the product of elapsed time and speed
// when that product saturates it; else they take two partial products of
// elapsed time by speed, one reciprocal multiply for the division by 1e6
// that yields the blend factor, and two partial products of the gap by
// that factor, all on one shared 32x32 multiplier. adaptive updates that
// decay a speed also spend one reciprocal multiply on the decay.
// the result sits in an output register; a stalled receiver holds the
// sequencer only when a second result is ready to be written.
// synchronous reset zeroes the bases, the snapshot time and the spike
// counter, sets both speeds to 0.3 and drops o_out.valid.
`include "adaptive_smooth_clock_defines.svh"

module adaptive_smooth_clock #(
    parameter int TIME_WIDTH = asc_pkg::TIME_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asc_in_if.sink     i_in,
    asc_out_if.source  o_out
);

    localparam int TW = TIME_WIDTH;

    asc_pkg::t_state r_state, n_state;

    logic [TW-1:0]                     r_cur, n_cur;
    logic [TW-1:0]                     r_tgt_base, n_tgt_base;
    logic [TW-1:0]                     r_snap, n_snap;
    logic [asc_pkg::SPD_W-1:0]         r_speed [2];
    logic [asc_pkg::SPD_W-1:0]         n_speed [2];
    logic [asc_pkg::SPIKE_W-1:0]       r_spike, n_spike;

    asc_pkg::t_op                      r_op, n_op;
    logic [TW-1:0]                     r_now, n_now;
    logic [TW-1:0]                     r_tgt, n_tgt;
    logic [asc_pkg::TL_W-1:0]          r_tl, n_tl;
    logic                              r_dir, n_dir;
    logic [asc_pkg::SPD_W-1:0]         r_spd, n_spd;
    logic                              r_take, n_take;

    logic [asc_pkg::PROD_W-1:0]        r_prod;
    logic [asc_pkg::PROD_W-1:0]        r_acc, n_acc;
    logic [asc_pkg::REM_W-1:0]         r_rem, n_rem;
    logic [asc_pkg::Q_W-1:0]           r_q, n_q;
    logic [TW-1:0]                     r_res, n_res;

    logic                              r_ovalid, n_ovalid;
    logic [asc_pkg::OUT_W-1:0]         r_otime, n_otime;
    logic                              r_oapplied, n_oapplied;
    logic [asc_pkg::SPIKE_W-1:0]       r_ospike, n_ospike;

    logic [31:0]                       mul_a, mul_b;

    logic [TW-1:0]                     dt, gap, mag, delta, sm;
    logic                              gneg;
    logic [asc_pkg::SPD_W-1:0]         sp, speed_dir, decay_q;
    logic [asc_pkg::PROD_W-1:0]        dt64, m64, p_sum;
    logic                              a_zero, a_cap;
    logic [asc_pkg::Q_W-1:0]           quo;
    logic [32:0]                       speed19;
    logic [asc_pkg::TL_W-1:0]          tl_mag;
    logic                              spike;
    logic [asc_pkg::SPIKE_W-1:0]       spike_add, spike_sat;
    logic                              accept;

    // smoothing terms from the current state
    assign dt        = r_now - r_snap;
    assign gap       = r_tgt_base - r_cur;
    assign gneg      = gap[TW-1];
    assign sp        = (!gneg && gap != '0) ? r_speed[1] : r_speed[0];
    assign mag       = gneg ? (TW'(0) - gap) : gap;
    assign dt64      = asc_pkg::PROD_W'(dt);
    assign m64       = asc_pkg::PROD_W'(mag);
    assign a_zero    = dt[TW-1] || (dt == '0) || (sp == '0);
    assign a_cap     = dt64 >= asc_pkg::DT_SAT;
    assign p_sum     = r_acc + {r_prod[31:0], 32'd0};
    // (p >> 6) * ceil(2^44/15625) >> 44 is p / 1e6 for p below 65536e6
    assign quo       = r_prod[asc_pkg::QUO_LSB +: asc_pkg::Q_W];
    assign delta     = gneg ? (TW'(0) - r_acc[TW-1:0]) : r_acc[TW-1:0];
    assign sm        = r_cur + dt + delta;

    // speed adaptation terms
    assign speed_dir = r_speed[r_dir];
    assign speed19   = 33'(speed_dir) * 33'd19;
    assign decay_q   = r_prod[61:34];
    assign tl_mag    = 32'd0 - r_tl;
    assign spike     = tl_mag > asc_pkg::SPIKE_LIMIT;
    assign spike_add = r_spike + asc_pkg::SPIKE_STEP;
    assign spike_sat = (spike_add > asc_pkg::SPIKE_MAX) ? asc_pkg::SPIKE_MAX : spike_add;

    assign accept    = i_in.valid && i_in.ready;

    assign i_in.ready             = (r_state == asc_pkg::S_IDLE);
    assign o_out.valid            = r_ovalid;
    assign o_out.smoothed_time_us = r_otime;
    assign o_out.update_applied   = r_oapplied;
    assign o_out.spike_level      = r_ospike;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            asc_pkg::S_DECAY: begin
                mul_a = {1'b0, speed19[32:2]};
                mul_b = asc_pkg::RECIP5;
            end
            asc_pkg::S_PROD_LO: begin
                mul_a = dt64[31:0];
                mul_b = 32'(sp);
            end
            asc_pkg::S_PROD_HI: begin
                mul_a = dt64[63:32];
                mul_b = 32'(sp);
            end
            asc_pkg::S_DIV: begin
                mul_a = 32'(r_rem);
                mul_b = asc_pkg::RECIP_US;
            end
            asc_pkg::S_MQ_LO: begin
                mul_a = m64[31:0];
                mul_b = 32'(quo);
            end
            asc_pkg::S_MQ_HI: begin
                mul_a = m64[63:32];
                mul_b = 32'(r_q);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_tgt_base = r_tgt_base;
        n_snap     = r_snap;
        n_speed    = r_speed;
        n_spike    = r_spike;
        n_op       = r_op;
        n_now      = r_now;
        n_tgt      = r_tgt;
        n_tl       = r_tl;
        n_dir      = r_dir;
        n_spd      = r_spd;
        n_take     = r_take;
        n_acc      = r_acc;
        n_rem      = r_rem;
        n_q        = r_q;
        n_res      = r_res;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_otime    = r_otime;
        n_oapplied = r_oapplied;
        n_ospike   = r_ospike;

        case (r_state)
            asc_pkg::S_IDLE: begin
                if (accept) begin
                    n_op    = asc_pkg::t_op'(i_in.operation);
                    n_now   = TW'(i_in.now_us);
                    n_tgt   = TW'(i_in.target_us);
                    n_tl    = i_in.time_left_us;
                    n_dir   = i_in.direction;
                    n_spd   = i_in.speed_value;
                    n_state = asc_pkg::S_OP;
                end
            end
            asc_pkg::S_OP: begin
                case (r_op)
                    asc_pkg::OP_RESET: begin
                        n_snap     = r_now;
                        n_cur      = r_tgt;
                        n_tgt_base = r_tgt;
                        n_speed[0] = asc_pkg::SPEED_RESET;
                        n_speed[1] = asc_pkg::SPEED_RESET;
                        n_res      = r_tgt;
                        n_take     = 1'b1;
                        n_state    = asc_pkg::S_OUT;
                    end
                    asc_pkg::OP_SET_SPEED: begin
                        n_speed[r_dir] = r_spd;
                        n_take         = 1'b0;
                        n_state        = asc_pkg::S_SETUP;
                    end
                    asc_pkg::OP_UPDATE: begin
                        if (r_tl[asc_pkg::TL_W-1]) begin
                            if (spike) begin
                                n_spike = spike_sat;
                            end
                            // a big late spike is ignored until the counter climbs
                            if (spike && spike_sat < asc_pkg::SPIKE_GATE) begin
                                n_take = 1'b0;
                            end else begin
                                n_take = 1'b1;
                                if (speed_dir < asc_pkg::SPEED_CEIL) begin
                                    n_speed[r_dir] = {speed_dir[asc_pkg::SPD_W-2:0], 1'b0};
                                end
                            end
                            n_state = asc_pkg::S_SETUP;
                        end else begin
                            if (r_spike != '0) begin
                                n_spike = r_spike - asc_pkg::SPIKE_W'(1);
                            end
                            n_take  = 1'b1;
                            n_state = asc_pkg::S_DECAY;
                        end
                    end
                    default: begin
                        n_take  = 1'b0;
                        n_state = asc_pkg::S_SETUP;
                    end
                endcase
            end
            asc_pkg::S_DECAY: begin
                n_state = asc_pkg::S_DECAY_WB;
            end
            asc_pkg::S_DECAY_WB: begin
                // speed*19/4 times ceil(2^34/5), shifted down, is speed*19/20
                n_speed[r_dir] = (decay_q < asc_pkg::SPEED_FLOOR) ? asc_pkg::SPEED_FLOOR
                                                                 : decay_q;
                n_state        = asc_pkg::S_SETUP;
            end
            asc_pkg::S_SETUP: begin
                if (a_zero) begin
                    n_acc   = '0;
                    n_state = asc_pkg::S_FINAL;
                end else if (a_cap) begin
                    n_acc   = m64;
                    n_state = asc_pkg::S_FINAL;
                end else begin
                    n_state = asc_pkg::S_PROD_LO;
                end
            end
            asc_pkg::S_PROD_LO: begin
                n_state = asc_pkg::S_PROD_HI;
            end
            asc_pkg::S_PROD_HI: begin
                n_acc   = r_prod;
                n_state = asc_pkg::S_PROD_SUM;
            end
            asc_pkg::S_PROD_SUM: begin
                // factor saturates at 1.0 once dt*speed reaches 65536e6
                if (p_sum >= asc_pkg::DT_SAT) begin
                    n_acc   = m64;
                    n_state = asc_pkg::S_FINAL;
                end else begin
                    n_rem   = p_sum[asc_pkg::US_SHIFT +: asc_pkg::REM_W];
                    n_state = asc_pkg::S_DIV;
                end
            end
            asc_pkg::S_DIV: begin
                n_state = asc_pkg::S_MQ_LO;
            end
            asc_pkg::S_MQ_LO: begin
                n_q     = quo;
                n_state = asc_pkg::S_MQ_HI;
            end
            asc_pkg::S_MQ_HI: begin
                n_acc   = {16'd0, r_prod[63:16]};
                n_state = asc_pkg::S_MQ_SUM;
            end
            asc_pkg::S_MQ_SUM: begin
                n_acc   = r_acc + {r_prod[47:0], 16'd0};
                n_state = asc_pkg::S_FINAL;
            end
            asc_pkg::S_FINAL: begin
                // after a take dt is zero, so the new base is also the result
                n_res = sm;
                if (r_take) begin
                    n_cur      = sm;
                    n_tgt_base = r_tgt;
                    n_snap     = r_now;
                end
                n_state = asc_pkg::S_OUT;
            end
            asc_pkg::S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid   = 1'b1;
                    n_otime    = asc_pkg::OUT_W'($signed(r_res));
                    n_oapplied = r_take;
                    n_ospike   = r_spike;
                    n_state    = asc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = asc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_tgt_base <= '0;
            r_snap     <= '0;
            r_speed[0] <= asc_pkg::SPEED_RESET;
            r_speed[1] <= asc_pkg::SPEED_RESET;
            r_spike    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_cur      <= n_cur;
            r_tgt_base <= n_tgt_base;
            r_snap     <= n_snap;
            r_speed    <= n_speed;
            r_spike    <= n_spike;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_now      <= n_now;
        r_tgt      <= n_tgt;
        r_tl       <= n_tl;
        r_dir      <= n_dir;
        r_spd      <= n_spd;
        r_take     <= n_take;
        r_prod     <= mul_a * mul_b;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_res      <= n_res;
        r_otime    <= n_otime;
        r_oapplied <= n_oapplied;
        r_ospike   <= n_ospike;
    end

    `ASC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_in.ready)
    `ASC_ASSERT(a_spike_bound, i_clk, i_rst_n, r_spike <= asc_pkg::SPIKE_MAX)
    `ASC_ASSERT(a_quo_bound, i_clk, i_rst_n, (r_state == asc_pkg::S_MQ_HI) |-> !r_q[asc_pkg::Q_W-1])
    `ASC_ASSERT(a_load_from_out, i_clk, i_rst_n, $rose(r_ovalid) |-> $past(r_state == asc_pkg::S_OUT))

endmodule

@@ test/smooth_clock_checker.sv @@
`timescale 1ns / 1ps

module smooth_clock_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asc_in_if         i_cmd,
    asc_out_if        i_res,
    output int        o_fail_count,
    output int        o_pending
);
    import asc_pkg::*;

    localparam logic [63:0] US_PER_S  = 64'd1000000;
    localparam logic [16:0] BLEND_ONE = 17'd65536;

    typedef struct packed {
        logic [OUT_W-1:0]   smoothed;
        logic               taken;
        logic [SPIKE_W-1:0] spikes;
    } t_clock_reading;

    // shadow of the block's clock state
    logic [47:0]        anchor;
    logic [47:0]        goal;
    logic [47:0]        snap_t;
    logic [SPD_W-1:0]   slew [2];
    logic [SPIKE_W-1:0] spike_cnt;

    t_clock_reading due_readings [$];

    // smoothed clock at local time now from the shadow state
    function automatic logic [47:0] smooth_at(input logic [47:0] now);
        logic [47:0]      dt;
        logic [47:0]      gap;
        logic [47:0]      mag;
        logic [47:0]      part;
        logic [SPD_W-1:0] rate;
        logic [63:0]      q;
        logic [16:0]      blend;
        logic [64:0]      prod;
        dt    = now - snap_t;
        gap   = goal - anchor;
        rate  = (!gap[47] && gap != 48'd0) ? slew[1] : slew[0];
        blend = 17'd0;
        if (!dt[47] && dt != 48'd0 && rate != '0) begin
            if (64'(dt) >= DT_SAT) begin
                blend = BLEND_ONE;
            end else begin
                q = (64'(dt) * 64'(rate)) / US_PER_S;
                blend = (q >= 64'(BLEND_ONE)) ? BLEND_ONE : q[16:0];
            end
        end
        mag  = gap[47] ? 48'(-gap) : gap;
        prod = 65'(mag) * 65'(blend);
        part = prod[63:16];
        return anchor + dt + (gap[47] ? 48'(-part) : part);
    endfunction

    function automatic t_clock_reading run_command(input t_op op, input logic [47:0] now,
                                                   input logic [47:0] tgt,
                                                   input logic [31:0] late, input logic dir,
                                                   input logic [SPD_W-1:0] spd);
        t_clock_reading r;
        logic           take;
        logic           spike;
        logic [31:0]    lag;
        logic [6:0]     bumped;
        r.taken = 1'b0;
        case (op)
            OP_RESET: begin
                snap_t  = now;
                anchor  = tgt;
                goal    = tgt;
                slew[0] = SPEED_RESET;
                slew[1] = SPEED_RESET;
                r.taken = 1'b1;
            end
            OP_UPDATE: begin
                take = 1'b1;
                if (late[31]) begin
                    lag   = -late;
                    spike = lag > SPIKE_LIMIT;
                    if (spike) begin
                        bumped    = 7'(spike_cnt) + 7'(SPIKE_STEP);
                        spike_cnt = (bumped > 7'(SPIKE_MAX)) ? SPIKE_MAX : bumped[5:0];
                    end
                    if (spike && spike_cnt < SPIKE_GATE)
                        take = 1'b0;
                    else if (slew[dir] < SPEED_CEIL)
                        slew[dir] = slew[dir] << 1;
                end else begin
                    if (spike_cnt != '0)
                        spike_cnt = spike_cnt - SPIKE_W'(1);
                    slew[dir] = SPD_W'((64'(slew[dir]) * 64'd19) / 64'd20);
                    if (slew[dir] < SPEED_FLOOR)
                        slew[dir] = SPEED_FLOOR;
                end
                if (take) begin
                    anchor  = smooth_at(now);
                    goal    = tgt;
                    snap_t  = now;
                    r.taken = 1'b1;
                end
            end
            OP_SET_SPEED: slew[dir] = spd;
            default: ;
        endcase
        r.smoothed = smooth_at(now);
        r.spikes   = spike_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_clock_reading want;
        if (!i_rst_n) begin
            anchor       = '0;
            goal         = '0;
            snap_t       = '0;
            slew[0]      = SPEED_RESET;
            slew[1]      = SPEED_RESET;
            spike_cnt    = '0;
            o_fail_count = 0;
            due_readings.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready)
                due_readings.insert(due_readings.size(),
                                    run_command(t_op'(i_cmd.operation),
                                                {1'b0, i_cmd.now_us}, i_cmd.target_us,
                                                i_cmd.time_left_us, i_cmd.direction,
                                                i_cmd.speed_value));
            if (i_res.valid && i_res.ready) begin
                if (due_readings.size() == 0) begin
                    $error("result beat with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = due_readings.pop_front();
                    if (i_res.smoothed_time_us !== want.smoothed) begin
                        $error("smoothed_time_us: expected %0d, got %0d",
                               $signed(want.smoothed), i_res.smoothed_time_us);
                        o_fail_count++;
                    end
                    if (i_res.update_applied !== want.taken) begin
                        $error("update_applied: expected %0d, got %0d",
                               want.taken, i_res.update_applied);
                        o_fail_count++;
                    end
                    if (i_res.spike_level !== want.spikes) begin
                        $error("spike_level: expected %0d, got %0d",
                               want.spikes, i_res.spike_level);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = due_readings.size();
    end

endmodule

@@ test/tb_adaptive_smooth_clock.sv @@
`timescale 1ns / 1ps

module tb_adaptive_smooth_clock;
    import asc_pkg::*;

    localparam int RANDOM_CMDS = 1700;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic idle_free;

    asc_in_if  cmd_if ();
    asc_out_if res_if ();

    adaptive_smooth_clock dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    smooth_clock_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic send_cmd(input t_op op, input logic [NOW_W-1:0] now,
                            input logic [47:0] tgt, input logic [31:0] late,
                            input logic dir, input logic [SPD_W-1:0] spd);
        int unsigned gap;
        gap = idle_free ? 0 : $urandom_range(3);
        repeat (gap) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_if.valid        <= 1'b1;
        cmd_if.operation    <= op;
        cmd_if.now_us       <= now;
        cmd_if.target_us    <= tgt;
        cmd_if.time_left_us <= late;
        cmd_if.direction    <= dir;
        cmd_if.speed_value  <= spd;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
    endtask

    task automatic drain_all();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // receiver side, long hold-offs on two fixed beats
    initial begin : drain
        int unsigned wait_cycles;
        int unsigned taken;
        taken = 0;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == 250 || taken == 1100)
                wait_cycles = HOLD_CYCLES;
            else if (idle_free)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(3);
            repeat (wait_cycles) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
            taken++;
        end
    end

    initial begin : watchdog
        int unsigned dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [NOW_W-1:0] loc_now;
        logic [47:0]      offset;
        logic [47:0]      tgt;
        logic [31:0]      late;
        logic [SPD_W-1:0] spd;
        logic [63:0]      wide;
        t_op              op;
        int               jit;
        int unsigned      r;
        int unsigned      spike_pct;

        idle_free           = 1'b0;
        i_rst_n             = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.operation    = OP_QUERY;
        cmd_if.now_us       = '0;
        cmd_if.target_us    = '0;
        cmd_if.time_left_us = '0;
        cmd_if.direction    = 1'b0;
        cmd_if.speed_value  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, negative elapsed time, spike gating
        send_cmd(OP_QUERY, '0, '0, '0, 1'b0, '0);
        send_cmd(OP_QUERY, '1, '0, '0, 1'b1, '0);
        send_cmd(OP_RESET, 47'd100, 48'h7FFF_FFFF_FFFF, '0, 1'b0, '0);
        send_cmd(OP_QUERY, 47'd50, '0, '0, 1'b0, '0);
        send_cmd(OP_RESET, '0, 48'h8000_0000_0000, '0, 1'b0, '0);
        send_cmd(OP_SET_SPEED, 47'd10, '0, '0, 1'b0, '1);
        send_cmd(OP_SET_SPEED, 47'd20, '0, '0, 1'b1, '0);
        send_cmd(OP_UPDATE, 47'd1000, 48'd5000, 32'h7FFF_FFFF, 1'b1, '0);
        send_cmd(OP_QUERY, 47'd2000, '0, '0, 1'b0, '0);
        send_cmd(OP_UPDATE, 47'd3000, 48'(-100000), 32'd0, 1'b0, '0);
        send_cmd(OP_QUERY, 47'd1000000, '0, '0, 1'b0, '0);
        send_cmd(OP_UPDATE, 47'd1500000, 48'd1400000, 32'(-50000), 1'b1, '0);
        send_cmd(OP_UPDATE, 47'd1600000, 48'd1700000, 32'(-50001), 1'b1, '0);
        send_cmd(OP_UPDATE, 47'd1700000, 48'd1650000, 32'h8000_0000, 1'b0, '0);
        send_cmd(OP_UPDATE, 47'd1800000, 48'd1900000, 32'(-60000), 1'b1, '0);
        repeat (7) send_cmd(OP_UPDATE, 47'd2000000, 48'd1990000, 32'(-1000000), 1'b0, '0);
        send_cmd(OP_UPDATE, 47'd2500000, 48'd2600000, 32'd5, 1'b0, '0);
        send_cmd(OP_RESET, 47'd123456, 48'd777, '0, 1'b0, '0);
        send_cmd(OP_QUERY, 47'd70000123456, '0, '0, 1'b1, '0);

        loc_now = 47'd5000000;
        offset  = 48'd0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            idle_free = (n >= 1200 && n < 1400);
            if (n == 600 || n == 1500)
                drain_all();
            spike_pct = ((n / 150) % 2) ? 30 : 4;
            if ($urandom_range(99) < 8) begin
                // noise: any field value at all
                wide = {$urandom, $urandom};
                op   = t_op'($urandom_range(3));
                send_cmd(op, wide[NOW_W-1:0], 48'({$urandom, $urandom}), $urandom,
                         1'($urandom), SPD_W'($urandom));
            end else begin
                r = $urandom_range(99);
                if (r < 70)
                    loc_now = loc_now + 47'($urandom_range(200000));
                else if (r < 88)
                    loc_now = loc_now + 47'($urandom_range(50000000));
                else if (r < 93)
                    loc_now = loc_now + (47'($urandom) << 6);
                else if (r < 97)
                    loc_now = loc_now - 47'($urandom_range(5000));
                r = $urandom_range(99);
                op = (r < 20) ? OP_QUERY : (r < 28) ? OP_RESET :
                     (r < 85) ? OP_UPDATE : OP_SET_SPEED;
                jit = ($urandom_range(9) == 0) ? int'($urandom) :
                      int'($urandom_range(200000)) - 100000;
                tgt = {1'b0, loc_now} + offset + 48'(jit);
                if (op == OP_RESET && $urandom_range(1) == 1)
                    offset = 48'(int'($urandom_range(2000000)) - 1000000);
                r = $urandom_range(99);
                if (r < spike_pct)
                    late = 32'(-(50001 + int'($urandom_range(2000000))));
                else if (r < spike_pct + 25)
                    late = 32'(-int'($urandom_range(50000)));
                else
                    late = 32'($urandom_range(200000));
                r = $urandom_range(99);
                spd = (r < 70) ? SPD_W'($urandom_range(4000000)) :
                      (r < 80) ? '0 : SPD_W'($urandom);
                send_cmd(op, loc_now, tgt, late, 1'($urandom), spd);
            end
        end

        drain_all();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/asc_pkg.sv
rtl/core/asc_in_if.sv
rtl/core/asc_out_if.sv
rtl/core/adaptive_smooth_clock.sv
test/smooth_clock_checker.sv
test/tb_adaptive_smooth_clock.sv
